### rtl/core/qetok_pkg.sv
// ----------------------------------------------------------------------------
// qetok_pkg: shared constants and types for the quoted escape tokenizer
// Character codes, the character width and the error codes reported per item.
// ----------------------------------------------------------------------------
package qetok_pkg;

  localparam int unsigned CHAR_W = 16;

  localparam logic [CHAR_W-1:0] C_BSL   = CHAR_W'(8'h5C);
  localparam logic [CHAR_W-1:0] C_QUOTE = CHAR_W'(8'h22);
  localparam logic [CHAR_W-1:0] C_TILDE = CHAR_W'(8'h7E);
  localparam logic [CHAR_W-1:0] C_SPACE = CHAR_W'(8'h20);
  localparam logic [CHAR_W-1:0] C_LC_N  = CHAR_W'(8'h6E);
  localparam logic [CHAR_W-1:0] C_LC_R  = CHAR_W'(8'h72);
  localparam logic [CHAR_W-1:0] C_LC_T  = CHAR_W'(8'h74);
  localparam logic [CHAR_W-1:0] C_LF    = CHAR_W'(8'h0A);
  localparam logic [CHAR_W-1:0] C_CR    = CHAR_W'(8'h0D);
  localparam logic [CHAR_W-1:0] C_TAB   = CHAR_W'(8'h09);

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_ESC    = 3'd1,
    ERR_SPLICE = 3'd2,
    ERR_QUOTE  = 3'd3,
    ERR_DANGLE = 3'd4
  } err_code_e;

endpackage

### rtl/core/quoted_escape_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// quoted_escape_tokenizer_unit: streaming shell-style command tokenizer
// One character per transfer in, one result per transfer out.
// ----------------------------------------------------------------------------
// Takes one character per cycle and returns exactly one result per character
// in the next cycle, through a single output register. Throughput is one
// character per clock: the five flag bits of tokenizer state are updated in
// the same cycle the character is taken, so the next character may follow
// at once. in_ready_o drops only while a result sits in the output register
// and the consumer is not taking it. Unquoted spaces split tokens, double
// quotes group text and are dropped, a backslash escapes one character
// (space, tilde, quote, backslash, n, r, t), and an unquoted tilde opening a
// token is flagged with insert_home_o for a downstream splice. An error ends
// the command early (command_end_o with error_code_o); the rest of that
// command up to and including its last character then yields all-zero
// results. All state clears after the last character of a command.
module quoted_escape_tokenizer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // character stream
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [qetok_pkg::CHAR_W-1:0] ch_i,
  input  logic                         last_i,
  // token stream
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         char_valid_o,
  output logic [qetok_pkg::CHAR_W-1:0] out_char_o,
  output logic                         insert_home_o,
  output logic                         token_end_o,
  output logic                         command_end_o,
  output logic [2:0]                   error_code_o
);
  import qetok_pkg::*;

  // tokenizer flags
  logic esc_q, esc_d;          // backslash seen, escaped char pending
  logic quote_q, quote_d;      // inside double quotes
  logic nonempty_q, nonempty_d; // current token has content
  logic closed_q, closed_d;    // previous char closed a quote
  logic failed_q, failed_d;    // error seen, drop rest of command

  // result register
  logic              out_valid_q, out_valid_d;
  logic              cv_q, cv_d;
  logic [CHAR_W-1:0] oc_q, oc_d;
  logic              home_q, home_d;
  logic              tend_q, tend_d;
  logic              cend_q, cend_d;
  err_code_e         err_q, err_d;

  logic in_xfer;
  logic closed_now;

  // a new character may enter whenever the result slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    cv_d       = 1'b0;
    oc_d       = '0;
    home_d     = 1'b0;
    tend_d     = 1'b0;
    cend_d     = 1'b0;
    err_d      = ERR_NONE;
    closed_now = 1'b0;
    esc_d      = esc_q;
    quote_d    = quote_q;
    nonempty_d = nonempty_q;
    closed_d   = closed_q;
    failed_d   = failed_q;

    if (!failed_q) begin
      // classify the character against the current flags
      priority if (closed_q && ch_i == C_QUOTE) begin
        // "abc""def": gluing two quoted strings is rejected
        err_d = ERR_SPLICE;
      end else if (ch_i == C_BSL) begin
        if (!esc_q) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          cv_d  = 1'b1;
          oc_d  = C_BSL;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        priority if (ch_i == C_SPACE || ch_i == C_TILDE || ch_i == C_QUOTE) begin
          cv_d = 1'b1;
          oc_d = ch_i;
        end else if (ch_i == C_LC_N) begin
          cv_d = 1'b1;
          oc_d = C_LF;
        end else if (ch_i == C_LC_R) begin
          cv_d = 1'b1;
          oc_d = C_CR;
        end else if (ch_i == C_LC_T) begin
          cv_d = 1'b1;
          oc_d = C_TAB;
        end else begin
          err_d = ERR_ESC;
        end
      end else if (ch_i == C_TILDE && !quote_q && !nonempty_q) begin
        home_d = 1'b1;
      end else if (ch_i == C_SPACE) begin
        if (quote_q) begin
          cv_d = 1'b1;
          oc_d = ch_i;
        end else if (nonempty_q) begin
          tend_d = 1'b1;
        end
      end else if (ch_i == C_QUOTE) begin
        quote_d    = !quote_q;
        closed_now = quote_q;
      end else begin
        cv_d = 1'b1;
        oc_d = ch_i;
      end

      // flag updates and end-of-command checks, using the updated flags
      if (err_d == ERR_NONE) begin
        if (cv_d || home_d) begin
          nonempty_d = 1'b1;
        end
        if (tend_d) begin
          nonempty_d = 1'b0;
        end
        closed_d = closed_now;
        if (last_i) begin
          cend_d = 1'b1;
          priority if (quote_d) begin
            err_d = ERR_QUOTE;
          end else if (esc_d) begin
            err_d = ERR_DANGLE;
          end else if (nonempty_d) begin
            tend_d = 1'b1;
          end else begin
            // balanced, no escape, empty token: nothing left to close
          end
        end
      end

      // an error item carries only the command end and the code
      if (err_d != ERR_NONE) begin
        cv_d     = 1'b0;
        oc_d     = '0;
        home_d   = 1'b0;
        tend_d   = 1'b0;
        cend_d   = 1'b1;
        failed_d = 1'b1;
      end
    end

    // last character of a command: start the next one from scratch
    if (last_i) begin
      esc_d      = 1'b0;
      quote_d    = 1'b0;
      nonempty_d = 1'b0;
      closed_d   = 1'b0;
      failed_d   = 1'b0;
    end
  end

  // result slot fills on an input transfer, empties on an output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= 1'b0;
      quote_q     <= 1'b0;
      nonempty_q  <= 1'b0;
      closed_q    <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        esc_q      <= esc_d;
        quote_q    <= quote_d;
        nonempty_q <= nonempty_d;
        closed_q   <= closed_d;
        failed_q   <= failed_d;
      end
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cv_q   <= cv_d;
      oc_q   <= oc_d;
      home_q <= home_d;
      tend_q <= tend_d;
      cend_q <= cend_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_valid_o  = cv_q;
  assign out_char_o    = oc_q;
  assign insert_home_o = home_q;
  assign token_end_o   = tend_q;
  assign command_end_o = cend_q;
  assign error_code_o  = err_q;

endmodule

### rtl/core/qetok_checker.sv
// ----------------------------------------------------------------------------
// qetok_checker: port-level checks for the tokenizer
// Watches the top-level ports and is bound to every tokenizer instance.
// ----------------------------------------------------------------------------
module qetok_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         char_valid_o,
  input logic [qetok_pkg::CHAR_W-1:0] out_char_o,
  input logic                         insert_home_o,
  input logic                         token_end_o,
  input logic                         command_end_o,
  input logic [2:0]                   error_code_o
);
  import qetok_pkg::*;

  // an error result carries nothing but the end of command
  a_err_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |->
      command_end_o && !char_valid_o && !insert_home_o && !token_end_o)
    else $error("error result carries token data");

  // no character means a zero character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> out_char_o == '0)
    else $error("out_char nonzero without char_valid");

  // a home splice never comes with a character; a lone tilde ending the
  // command may also end its token
  a_home_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && insert_home_o |-> !char_valid_o)
    else $error("home splice mixed with a character");

  // a result taken with no character transfer leaves the slot empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result repeated");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(error_code_o))
    else $error("stalled result changed");

endmodule

bind quoted_escape_tokenizer_unit qetok_checker u_qetok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .char_valid_o  (char_valid_o),
  .out_char_o    (out_char_o),
  .insert_home_o (insert_home_o),
  .token_end_o   (token_end_o),
  .command_end_o (command_end_o),
  .error_code_o  (error_code_o)
);

### sim/tb_quoted_escape_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_escape_tokenizer_unit: self-checking bench for the shell tokenizer
// Runs a short directed table of commands, then random commands (mostly
// well-formed, some noise) under several idle and stall mixes. Each result is
// checked field by field against a typed expectation or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_quoted_escape_tokenizer_unit;
  import qetok_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  // Random characters per idle/stall phase.
  localparam int unsigned PHASE_ITEMS = 125;

  // One token-stream result, as it leaves the block.
  typedef struct packed {
    logic              cv;
    logic [CHAR_W-1:0] oc;
    logic              home;
    logic              tend;
    logic              cend;
    err_code_e         err;
  } tok_res_t;

  // Directed row: typed rows carry a hand-written expectation, the others
  // take whatever the model predicts.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    bit                typed;
    tok_res_t          res;
  } dir_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [CHAR_W-1:0] ch_i          = '0;
  logic              last_i        = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              char_valid_o;
  logic [CHAR_W-1:0] out_char_o;
  logic              insert_home_o;
  logic              token_end_o;
  logic              command_end_o;
  logic [2:0]        error_code_o;

  // Tokenizer state as the model tracks it.
  logic esc_pend;
  logic in_quote;
  logic tok_open;
  logic quote_closed;
  logic cmd_failed;

  tok_res_t    token_results_q[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;

  quoted_escape_tokenizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_valid_o  (char_valid_o),
    .out_char_o    (out_char_o),
    .insert_home_o (insert_home_o),
    .token_end_o   (token_end_o),
    .command_end_o (command_end_o),
    .error_code_o  (error_code_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic void clear_tok_state();
    esc_pend     = 1'b0;
    in_quote     = 1'b0;
    tok_open     = 1'b0;
    quote_closed = 1'b0;
    cmd_failed   = 1'b0;
  endfunction

  function automatic tok_res_t res_of(logic cv, logic [CHAR_W-1:0] oc, logic home,
                                      logic tend, logic cend, err_code_e err);
    tok_res_t r;
    r.cv   = cv;
    r.oc   = oc;
    r.home = home;
    r.tend = tend;
    r.cend = cend;
    r.err  = err;
    return r;
  endfunction

  // Advances the tokenizer by one character and returns its result.
  function automatic tok_res_t tokenize_char(logic [CHAR_W-1:0] c, logic l);
    tok_res_t r;
    logic     closed_now;
    r          = '0;
    r.err      = ERR_NONE;
    closed_now = 1'b0;
    if (cmd_failed) begin
      // rest of a failed command is swallowed silently
      if (l) clear_tok_state();
    end else begin
      if (quote_closed && c == C_QUOTE) begin
        r.err = ERR_SPLICE;
      end else if (c == C_BSL) begin
        if (!esc_pend) begin
          esc_pend = 1'b1;
        end else begin
          esc_pend = 1'b0;
          r.cv = 1'b1;
          r.oc = C_BSL;
        end
      end else if (esc_pend) begin
        esc_pend = 1'b0;
        r.cv     = 1'b1;
        case (c)
          C_SPACE, C_TILDE, C_QUOTE: r.oc = c;
          C_LC_N: r.oc = C_LF;
          C_LC_R: r.oc = C_CR;
          C_LC_T: r.oc = C_TAB;
          default: r.err = ERR_ESC;
        endcase
      end else if (c == C_TILDE && !in_quote && !tok_open) begin
        r.home = 1'b1;
      end else if (c == C_SPACE) begin
        if (in_quote) begin
          r.cv = 1'b1;
          r.oc = c;
        end else if (tok_open) begin
          r.tend = 1'b1;
        end
      end else if (c == C_QUOTE) begin
        in_quote   = !in_quote;
        closed_now = !in_quote;
      end else begin
        r.cv = 1'b1;
        r.oc = c;
      end

      if (r.err == ERR_NONE) begin
        if (r.cv || r.home) tok_open = 1'b1;
        if (r.tend) tok_open = 1'b0;
        quote_closed = closed_now;
        if (l) begin
          r.cend = 1'b1;
          if (in_quote) r.err = ERR_QUOTE;
          else if (esc_pend) r.err = ERR_DANGLE;
          else if (tok_open) r.tend = 1'b1;
        end
      end

      if (r.err != ERR_NONE) begin
        r.cv       = 1'b0;
        r.oc       = '0;
        r.home     = 1'b0;
        r.tend     = 1'b0;
        r.cend     = 1'b1;
        cmd_failed = 1'b1;
      end
      if (l) clear_tok_state();
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Character sources for random commands
  // --------------------------------------------------------------------------
  // Anything that is neither a separator, a quote nor an escape lead-in.
  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(3))
      0: c = CHAR_W'($urandom_range(16'h0061, 16'h007A));
      1: c = C_TAB;
      default: c = CHAR_W'($urandom);
    endcase
    if (c == C_BSL || c == C_QUOTE || c == C_SPACE) c = C_LC_T;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] esc_char();
    case ($urandom_range(6))
      0: return C_SPACE;
      1: return C_TILDE;
      2: return C_QUOTE;
      3: return C_BSL;
      4: return C_LC_N;
      5: return C_LC_R;
      default: return C_LC_T;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Called right after a rising edge. Returns right after the edge at which
  // the character transferred, with the expectation queued.
  task automatic send_char(logic [CHAR_W-1:0] c, logic l, bit typed, tok_res_t typed_res);
    tok_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= l;
    // ready is settled by the falling edge and holds until the next rise
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    r = tokenize_char(c, l);
    token_results_q.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // Mostly well-formed commands with random content; about one in five is
  // raw noise heavy in quotes, backslashes, spaces and tildes.
  task automatic send_random_command();
    logic [CHAR_W-1:0] cmd[$];
    bit                after_close;
    int unsigned       n;
    after_close = 1'b0;
    if ($urandom_range(99) < 80) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(5))
          0: begin
            cmd.push_back(plain_char());
            after_close = 1'b0;
          end
          1: begin
            repeat ($urandom_range(1, 2)) cmd.push_back(C_SPACE);
            after_close = 1'b0;
          end
          2: begin
            cmd.push_back(C_TILDE);
            after_close = 1'b0;
          end
          3: begin
            cmd.push_back(C_BSL);
            cmd.push_back(esc_char());
            after_close = 1'b0;
          end
          4: begin
            // a second quoted run straight after a close would be a splice
            if (after_close) cmd.push_back(plain_char());
            cmd.push_back(C_QUOTE);
            repeat ($urandom_range(0, 3)) begin
              case ($urandom_range(2))
                0: cmd.push_back(C_SPACE);
                1: cmd.push_back(plain_char());
                default: begin
                  cmd.push_back(C_BSL);
                  cmd.push_back(esc_char());
                end
              endcase
            end
            cmd.push_back(C_QUOTE);
            after_close = 1'b1;
          end
          default: begin
            repeat ($urandom_range(1, 3)) cmd.push_back(plain_char());
            after_close = 1'b0;
          end
        endcase
      end
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(7))
          0: cmd.push_back(C_BSL);
          1: cmd.push_back(C_QUOTE);
          2: cmd.push_back(C_SPACE);
          3: cmd.push_back(C_TILDE);
          4: cmd.push_back(esc_char());
          default: cmd.push_back(CHAR_W'($urandom));
        endcase
      end
    end
    foreach (cmd[i]) send_char(cmd[i], i == cmd.size() - 1, 1'b0, '0);
  endtask

  // Holds the input quiet until every queued result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (token_results_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Everything is sampled at the falling edge: inputs move only at the rising
  // edge, so what is seen here is what the next rising edge transfers.
  always @(negedge clk_i) begin
    tok_res_t got;
    tok_res_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end

    if (out_valid_o && out_ready_i) begin
      got = res_of(char_valid_o, out_char_o, insert_home_o, token_end_o, command_end_o,
                   err_code_e'(error_code_o));
      if (token_results_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatch_cnt++;
      end else begin
        want = token_results_q.pop_front();
        if (got.cv !== want.cv) begin
          $error("char_valid: expected %0d, got %0d", want.cv, got.cv);
          mismatch_cnt++;
        end
        if (got.oc !== want.oc) begin
          $error("out_char: expected %h, got %h", want.oc, got.oc);
          mismatch_cnt++;
        end
        if (got.home !== want.home) begin
          $error("insert_home: expected %0d, got %0d", want.home, got.home);
          mismatch_cnt++;
        end
        if (got.tend !== want.tend) begin
          $error("token_end: expected %0d, got %0d", want.tend, got.tend);
          mismatch_cnt++;
        end
        if (got.cend !== want.cend) begin
          $error("command_end: expected %0d, got %0d", want.cend, got.cend);
          mismatch_cnt++;
        end
        if (error_code_o !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, error_code_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    tok_res_t none;
    none = res_of(1'b0, '0, 1'b0, 1'b0, 1'b0, ERR_NONE);
    clear_tok_state();

    // One long command walking the escapes and quoting, closed by a splice,
    // then short commands for each end-of-command error and a lone tilde.
    dir_rows.push_back('{16'h0061, 1'b0, 1'b1,
                         res_of(1'b1, 16'h0061, 1'b0, 1'b0, 1'b0, ERR_NONE)});
    dir_rows.push_back('{16'hFFFF, 1'b0, 1'b1,
                         res_of(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, ERR_NONE)});
    dir_rows.push_back('{16'h0000, 1'b0, 1'b1,
                         res_of(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, ERR_NONE)});
    dir_rows.push_back('{C_SPACE, 1'b0, 1'b1,
                         res_of(1'b0, '0, 1'b0, 1'b1, 1'b0, ERR_NONE)});
    dir_rows.push_back('{C_TILDE, 1'b0, 1'b1,
                         res_of(1'b0, '0, 1'b1, 1'b0, 1'b0, ERR_NONE)});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b1, none});
    dir_rows.push_back('{C_LC_N, 1'b0, 1'b1,
                         res_of(1'b1, C_LF, 1'b0, 1'b0, 1'b0, ERR_NONE)});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_LC_R, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_LC_T, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_SPACE, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_TILDE, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_QUOTE, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_QUOTE, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_QUOTE, 1'b0, 1'b0, none});
    dir_rows.push_back('{C_QUOTE, 1'b0, 1'b1,
                         res_of(1'b0, '0, 1'b0, 1'b0, 1'b1, ERR_SPLICE)});
    dir_rows.push_back('{C_TAB, 1'b1, 1'b1, none});
    dir_rows.push_back('{C_BSL, 1'b0, 1'b0, none});
    dir_rows.push_back('{16'h0071, 1'b1, 1'b1,
                         res_of(1'b0, '0, 1'b0, 1'b0, 1'b1, ERR_ESC)});
    dir_rows.push_back('{C_QUOTE, 1'b1, 1'b1,
                         res_of(1'b0, '0, 1'b0, 1'b0, 1'b1, ERR_QUOTE)});
    dir_rows.push_back('{C_BSL, 1'b1, 1'b1,
                         res_of(1'b0, '0, 1'b0, 1'b0, 1'b1, ERR_DANGLE)});
    dir_rows.push_back('{C_TILDE, 1'b1, 1'b0, none});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phases: no idling, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      int unsigned start;
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
        end
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_command();
      // let the pipe run dry between phases
      drain_results();
    end

    // drain_results leaves the queue empty; a few more cycles catch strays
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
